// File: hdl/sfr_pkg.sv
// shared constants, types and helpers for the stream find-and-replace block
`default_nettype none

package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BURST_DEPTH     = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                      : MAX_REPLACEMENT;
    localparam int CNT_W           = $clog2(BURST_DEPTH + 1);

    localparam int LEN_W   = 4;
    localparam int WORD_W  = 64;
    localparam int ADDR_W  = 5;
    localparam int BYTE_W  = 8;

    typedef enum logic [1:0] {
        REG_PATTERN_LENGTH     = 2'd0,
        REG_PATTERN_BYTES      = 2'd1,
        REG_REPLACEMENT_LENGTH = 2'd2,
        REG_REPLACEMENT_BYTES  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0]  plen;
        logic [WORD_W-1:0] pat;
        logic [CNT_W-1:0]  rlen;
        logic [WORD_W-1:0] repl;
        logic              clear;
    } cfg_t;

    typedef struct packed {
        logic en;
        logic shift;
        logic take_new;
    } win_ctl_t;

    typedef struct packed {
        logic load;
        logic shift;
    } out_ctl_t;

    function automatic logic [CNT_W-1:0] sat_plen(input logic [LEN_W-1:0] raw);
        logic [CNT_W-1:0] n;
        n = CNT_W'(raw);
        if (raw == '0) begin
            n = CNT_W'(1);
        end else if (32'(raw) > MAX_PATTERN) begin
            n = CNT_W'(MAX_PATTERN);
        end
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] sat_rlen(input logic [LEN_W-1:0] raw);
        logic [CNT_W-1:0] n;
        n = CNT_W'(raw);
        if (32'(raw) > MAX_REPLACEMENT) begin
            n = CNT_W'(MAX_REPLACEMENT);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/sfr_cfg.sv
// apb register file holding pattern and replacement settings
`default_nettype none

module sfr_cfg
    import sfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [LEN_W-1:0]  plen_reg,  plen_next;
    logic [WORD_W-1:0] pat_reg,   pat_next;
    logic [LEN_W-1:0]  rlen_reg,  rlen_next;
    logic [WORD_W-1:0] repl_reg,  repl_next;
    logic              clear_next;
    reg_idx_t          idx;
    logic              wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr     = psel && penable && pwrite && pready;

    always_comb begin
        plen_next  = plen_reg;
        pat_next   = pat_reg;
        rlen_next  = rlen_reg;
        repl_next  = repl_reg;
        clear_next = 1'b0;
        if (wr) begin
            unique case (idx)
                REG_PATTERN_LENGTH: begin
                    plen_next  = pwdata[LEN_W-1:0];
                    clear_next = 1'b1;
                end
                REG_PATTERN_BYTES:      pat_next  = pwdata;
                REG_REPLACEMENT_LENGTH: rlen_next = pwdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  repl_next = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PATTERN_LENGTH:     prdata = WORD_W'(plen_reg);
            REG_PATTERN_BYTES:      prdata = pat_reg;
            REG_REPLACEMENT_LENGTH: prdata = WORD_W'(rlen_reg);
            REG_REPLACEMENT_BYTES:  prdata = repl_reg;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg  <= LEN_W'(1);
            pat_reg   <= '0;
            rlen_reg  <= '0;
            repl_reg  <= '0;
        end else begin
            plen_reg  <= plen_next;
            pat_reg   <= pat_next;
            rlen_reg  <= rlen_next;
            repl_reg  <= repl_next;
        end
    end

    // clear is combinational so the window empties at the same edge as the write
    assign cfg.plen  = sat_plen(plen_reg);
    assign cfg.pat   = pat_reg;
    assign cfg.rlen  = sat_rlen(rlen_reg);
    assign cfg.repl  = repl_reg;
    assign cfg.clear = clear_next;

endmodule

`default_nettype wire

// File: hdl/sfr_win_cell.sv
// one window cell: holds a pending byte and compares it to its pattern byte
`default_nettype none

module sfr_win_cell
    import sfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire win_ctl_t          ctl,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic [BYTE_W-1:0] nb_view,
    input  wire logic [BYTE_W-1:0] pat_byte,
    output logic      [BYTE_W-1:0] view,
    output logic                   match
);

    logic [BYTE_W-1:0] byte_reg, byte_next;

    // view is the window contents with the incoming byte already placed
    assign view  = ctl.take_new ? in_byte : byte_reg;
    assign match = (view == pat_byte);

    always_comb begin
        byte_next = byte_reg;
        if (ctl.en) begin
            byte_next = ctl.shift ? nb_view : view;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

// File: hdl/sfr_out_cell.sv
// one output cell: holds a queued result byte and shifts toward the port
`default_nettype none

module sfr_out_cell
    import sfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire out_ctl_t          ctl,
    input  wire logic [BYTE_W-1:0] load_byte,
    input  wire logic [BYTE_W-1:0] nb_byte,
    output logic      [BYTE_W-1:0] q
);

    logic [BYTE_W-1:0] byte_reg, byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.load) begin
            byte_next = load_byte;
        end else if (ctl.shift) begin
            byte_next = nb_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

`default_nettype wire

// File: hdl/stream_find_replace.sv
// top level of the streaming find-and-replace-all block
//
//  channel   ports                               role
//  s_        s_valid s_ready s_in_byte           source bytes, one beat per byte
//            s_final_byte
//  m_        m_valid m_ready m_out_byte          rewritten bytes and end marker
//            m_byte_valid m_end_of_string
//  apb       psel penable pwrite paddr pwdata    pattern and replacement registers
//            prdata pready
//
//  an input beat is taken when s_valid and s_ready are high; a beat that yields
//  n results holds s_ready low while the output cell row drains (n up to 8)
//  a beat that yields at most one result sustains one beat per cycle while m_ready is high
//  results are registered in the output cell row and appear in the cycle after the input beat that causes them
//  synchronous active-low reset empties the window and the output row
//  m_ready low stalls the output row and, while it holds any beat, s_ready
`default_nettype none

module stream_find_replace
    import sfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_in_byte,
    input  wire logic              s_final_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [BYTE_W-1:0] m_out_byte,
    output logic                   m_byte_valid,
    output logic                   m_end_of_string,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready
);

    cfg_t cfg;

    logic [CNT_W-1:0] win_cnt_reg, win_cnt_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic             end_reg, end_next;
    logic             bare_reg, bare_next;

    logic [BYTE_W-1:0] view  [MAX_PATTERN];
    logic              match [MAX_PATTERN];
    logic [BYTE_W-1:0] oq    [BURST_DEPTH];
    logic [BYTE_W-1:0] burst [BURST_DEPTH];

    logic             s_hs, m_hs;
    logic [CNT_W-1:0] new_cnt;
    logic             cmp, hit, hit_cmp, miss_cmp;
    logic             sel_repl, bare;
    logic [CNT_W-1:0] burst_len;
    logic             load;

    sfr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready = (out_cnt_reg == '0) || ((out_cnt_reg == CNT_W'(1)) && m_ready);
    assign s_hs    = s_valid && s_ready;
    assign m_hs    = m_valid && m_ready;
    assign new_cnt = win_cnt_reg + CNT_W'(1);
    assign cmp     = (new_cnt == cfg.plen);

    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((CNT_W'(i) < cfg.plen) && !match[i]) begin
                hit = 1'b0;
            end
        end
    end

    assign hit_cmp  = cmp && hit;
    assign miss_cmp = cmp && !hit;

    // window row
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
        win_ctl_t          wctl;
        logic [BYTE_W-1:0] nb;

        assign wctl.en       = s_hs;
        assign wctl.shift    = miss_cmp;
        assign wctl.take_new = (win_cnt_reg == CNT_W'(i));
        if (i == MAX_PATTERN - 1) begin : g_tail
            assign nb = view[i];
        end else begin : g_mid
            assign nb = view[i+1];
        end

        sfr_win_cell u_cell (
            .aclk     (aclk),
            .ctl      (wctl),
            .in_byte  (s_in_byte),
            .nb_view  (nb),
            .pat_byte (cfg.pat[i*BYTE_W +: BYTE_W]),
            .view     (view[i]),
            .match    (match[i])
        );
    end

    // results of one beat are none, the replacement, a prefix of the window, or a bare end marker
    always_comb begin
        sel_repl  = hit_cmp;
        burst_len = '0;
        if (hit_cmp) begin
            burst_len = cfg.rlen;
        end else if (miss_cmp) begin
            burst_len = s_final_byte ? cfg.plen : CNT_W'(1);
        end else if (s_final_byte) begin
            burst_len = new_cnt;
        end
        bare = 1'b0;
        if (s_final_byte && (burst_len == '0)) begin
            bare      = 1'b1;
            burst_len = CNT_W'(1);
        end
    end

    for (genvar i = 0; i < BURST_DEPTH; i++) begin : g_burst
        logic [BYTE_W-1:0] rb, wb;
        if (i < MAX_REPLACEMENT) begin : g_r
            assign rb = cfg.repl[i*BYTE_W +: BYTE_W];
        end else begin : g_nr
            assign rb = '0;
        end
        if (i < MAX_PATTERN) begin : g_w
            assign wb = view[i];
        end else begin : g_nw
            assign wb = '0;
        end
        assign burst[i] = bare ? '0 : (sel_repl ? rb : wb);
    end

    assign load = s_hs && (burst_len != '0);

    // output row
    for (genvar i = 0; i < BURST_DEPTH; i++) begin : g_out
        out_ctl_t          octl;
        logic [BYTE_W-1:0] nb;

        assign octl.load  = load;
        assign octl.shift = m_hs;
        if (i == BURST_DEPTH - 1) begin : g_tail
            assign nb = '0;
        end else begin : g_mid
            assign nb = oq[i+1];
        end

        sfr_out_cell u_cell (
            .aclk      (aclk),
            .ctl       (octl),
            .load_byte (burst[i]),
            .nb_byte   (nb),
            .q         (oq[i])
        );
    end

    always_comb begin
        win_cnt_next = win_cnt_reg;
        if (cfg.clear) begin
            win_cnt_next = '0;
        end else if (s_hs) begin
            if (s_final_byte || hit_cmp) begin
                win_cnt_next = '0;
            end else if (miss_cmp) begin
                win_cnt_next = cfg.plen - CNT_W'(1);
            end else begin
                win_cnt_next = new_cnt;
            end
        end
    end

    always_comb begin
        out_cnt_next = out_cnt_reg;
        end_next     = end_reg;
        bare_next    = bare_reg;
        if (load) begin
            out_cnt_next = burst_len;
            end_next     = s_final_byte;
            bare_next    = bare;
        end else if (m_hs) begin
            out_cnt_next = out_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cnt_reg <= '0;
            out_cnt_reg <= '0;
            end_reg     <= 1'b0;
            bare_reg    <= 1'b0;
        end else begin
            win_cnt_reg <= win_cnt_next;
            out_cnt_reg <= out_cnt_next;
            end_reg     <= end_next;
            bare_reg    <= bare_next;
        end
    end

    assign m_valid         = (out_cnt_reg != '0);
    assign m_out_byte      = oq[0];
    assign m_byte_valid    = !bare_reg;
    assign m_end_of_string = end_reg && (out_cnt_reg == CNT_W'(1));

    a_win_below_plen: assert property (@(posedge aclk) disable iff (!aresetn)
        win_cnt_reg < cfg.plen)
        else $error("window count reached pattern length");

    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> m_end_of_string)
        else $error("bare marker beat without end of string");

    a_final_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && s_final_byte) |=> (win_cnt_reg == '0))
        else $error("window not empty after final byte");

    a_out_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= CNT_W'(BURST_DEPTH))
        else $error("output row overfilled");

endmodule

`default_nettype wire
